/* design/srm_pkg.sv */
package srm_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned PULSES_PER_TURN_DEF = 1;
    localparam int unsigned LOAD_ACTIVE_DEF     = 0;
    localparam int unsigned TIMER_PASSES_DEF    = 4;

    // Microseconds per minute, the numerator of every speed conversion
    localparam logic [25:0] RPM_NUMERATOR = 26'd60000000;
    localparam int unsigned DIV_STEPS     = 26;

    // Event kinds on the input channel
    localparam logic [1:0] FN_EDGE = 2'd0;
    localparam logic [1:0] FN_LOAD = 2'd1;

    // Configuration register indexes
    localparam logic [2:0] CFG_MIN_PERIOD  = 3'd0;
    localparam logic [2:0] CFG_MAX_PERIOD  = 3'd1;
    localparam logic [2:0] CFG_RPM_LIMIT   = 3'd2;
    localparam logic [2:0] CFG_FINISH_PCT  = 3'd3;
    localparam logic [2:0] CFG_DEBOUNCE    = 3'd4;
    localparam logic [2:0] CFG_ZERO_TO     = 3'd5;
    localparam logic [2:0] CFG_IDLE_RESET  = 3'd6;
    localparam logic [2:0] CFG_NO_RPM_TO   = 3'd7;

    // Reference polarity not yet chosen
    localparam logic [1:0] REF_NONE = 2'd2;

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_READY  = 2'd1,
        PH_SPIN   = 2'd2,
        PH_LAUNCH = 2'd3
    } phase_t;

    // Timer kinds in tie-break order
    typedef enum logic [1:0] {
        TK_LOAD  = 2'd0,
        TK_ZERO  = 2'd1,
        TK_IDLE  = 2'd2,
        TK_NORPM = 2'd3
    } tkind_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic   start;
        logic   scan;
        logic   scan_first;
        tkind_t kind;
        logic   apply;
        logic   check;
        logic   ev_edge;
        logic   ev_load;
        logic   div_init;
        logic   div_step;
        logic   rpm;
        logic   latch;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic sel_valid;
        logic fin;
        logic need_div;
        logic is_edge;
        logic is_load;
    } sts_t;

endpackage

/* design/spin_rpm_meter_with_launch_detect.sv */
// Period-based spin tachometer with launcher load sensing and launch detection.
// Each input transfer carries one time-stamped event (speed edge, load level
// change or time tick) and produces exactly one result transfer. Items are
// handled one at a time: each item runs up to TIMER_PASSES timer passes, then
// its event. Each timer pass scans the four deadlines one per cycle, then
// handles and checks the winner; a pass that finds nothing due ends the scan.
// A speed edge that yields a usable period then loads the restoring divider,
// runs its 26 divide steps, and takes and checks the speed. The result sits in
// an output register, so a new item is taken while the previous result still
// waits on out_stall. Configuration writes are always ready and must only be
// issued while idle.
module spin_rpm_meter_with_launch_detect #(
    parameter int unsigned PULSES_PER_TURN = srm_pkg::PULSES_PER_TURN_DEF,
    parameter int unsigned LOAD_ACTIVE     = srm_pkg::LOAD_ACTIVE_DEF,
    parameter int unsigned TIMER_PASSES    = srm_pkg::TIMER_PASSES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [29:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] time_us,
    input  logic        level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] current_rpm,
    output logic [15:0] peak_rpm,
    output logic [1:0]  phase,
    output logic        loaded,
    output logic        finished,
    output logic        launched,
    output logic        period_valid,
    output logic [26:0] turn_period,
    output logic        is_reference_edge
);
    import srm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    srm_ctrl #(
        .TIMER_PASSES (TIMER_PASSES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    srm_dp #(
        .PULSES_PER_TURN (PULSES_PER_TURN),
        .LOAD_ACTIVE     (LOAD_ACTIVE)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .cmd               (cmd),
        .sts               (sts),
        .func              (func),
        .time_us           (time_us),
        .level             (level),
        .current_rpm       (current_rpm),
        .peak_rpm          (peak_rpm),
        .phase             (phase),
        .loaded            (loaded),
        .finished          (finished),
        .launched          (launched),
        .period_valid      (period_valid),
        .turn_period       (turn_period),
        .is_reference_edge (is_reference_edge)
    );

endmodule

/* design/srm_dp.sv */
module srm_dp #(
    parameter int unsigned PULSES_PER_TURN = srm_pkg::PULSES_PER_TURN_DEF,
    parameter int unsigned LOAD_ACTIVE     = srm_pkg::LOAD_ACTIVE_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    input  logic [2:0]    cfg_index,
    input  logic [29:0]   cfg_data,
    input  srm_pkg::cmd_t cmd,
    output srm_pkg::sts_t sts,
    input  logic [1:0]    func,
    input  logic [31:0]   time_us,
    input  logic          level,
    output logic [15:0]   current_rpm,
    output logic [15:0]   peak_rpm,
    output logic [1:0]    phase,
    output logic          loaded,
    output logic          finished,
    output logic          launched,
    output logic          period_valid,
    output logic [26:0]   turn_period,
    output logic          is_reference_edge
);
    import srm_pkg::*;

    localparam int unsigned PW = $clog2(PULSES_PER_TURN + 1);
    localparam int unsigned DW = 27 + PW;
    localparam logic [PW-1:0] PPT = PW'(PULSES_PER_TURN);
    localparam logic LOAD_LVL = 1'(LOAD_ACTIVE);

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  based;
        logic [1:0]  ref_pol;
        logic        quiet;
        logic        have;
        logic [15:0] now;
        logic [15:0] peak;
        logic        fin;
        logic        lch;
        logic        pend;
        logic        pend_quiet;
    } run_t;

    function automatic logic before_f(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic run_t restart_f(run_t s, logic ld);
        run_t r;
        r = s;
        r.based   = 2'b00;
        r.ref_pol = REF_NONE;
        r.quiet   = 1'b1;
        r.have    = 1'b0;
        r.now     = 16'd0;
        r.peak    = 16'd0;
        r.phase   = ld ? PH_READY : PH_WAIT;
        return r;
    endfunction

    function automatic run_t end_run_f(run_t s);
        run_t r;
        r = s;
        if (s.phase == PH_LAUNCH)
        begin
            if (!s.have)
            begin
                r = restart_f(s, 1'b0);
            end
            else
            begin
                r.fin   = 1'b1;
                r.phase = PH_WAIT;
                r.now   = 16'd0;
                r.based = 2'b00;
                r.quiet = 1'b1;
            end
        end
        return r;
    endfunction

    // now <= ceil(peak * pct / 100)  <=>  peak * pct + 99 >= now * 100
    function automatic logic thr_hit(run_t s, logic [6:0] pct);
        logic [23:0] lhs;
        logic [23:0] rhs;
        lhs = 24'(s.peak) * 24'(pct) + 24'd99;
        rhs = 24'(s.now) * 24'd100;
        return (s.phase == PH_LAUNCH) && s.have && (s.now != 16'd0)
            && (s.peak != 16'd0) && (lhs >= rhs);
    endfunction

    // Configuration
    logic [19:0] min_period_reg;
    logic [26:0] max_period_reg;
    logic [15:0] rpm_limit_reg;
    logic [6:0]  finish_pct_reg;
    logic [26:0] debounce_reg;
    logic [29:0] zero_to_reg;
    logic [29:0] idle_reg;
    logic [29:0] no_rpm_reg;

    // Current item
    logic [1:0]  func_reg;
    logic [31:0] t_reg;
    logic        lvl_reg;

    // Block state
    logic        raw_reg, raw_next;
    logic        stable_reg, stable_next;
    logic [31:0] cand_time_reg, cand_time_next;
    logic        cand_spin_reg, cand_spin_next;
    logic [31:0] last_edge_reg [2];
    logic [31:0] last_edge_next [2];
    logic [31:0] last_act_reg, last_act_next;
    logic [31:0] launch_time_reg, launch_time_next;
    run_t        run_reg, run_next;
    logic        pval_reg, pval_next;
    logic        pref_reg, pref_next;
    logic [26:0] period_reg, period_next;

    // Timer selection
    logic        sel_valid_reg, sel_valid_next;
    tkind_t      sel_kind_reg, sel_kind_next;
    logic [31:0] sel_dl_reg, sel_dl_next;

    // Divider
    logic [DW-1:0] dvs_reg;
    logic [DW-1:0] rem_reg;
    logic [25:0]   quo_reg;
    logic [DW:0]   trial;
    logic          trial_ge;

    // Output holding
    logic [15:0] o_now_reg, o_peak_reg;
    logic [1:0]  o_phase_reg;
    logic        o_loaded_reg, o_fin_reg, o_lch_reg, o_pval_reg, o_ref_reg;
    logic [26:0] o_period_reg;

    logic        tick;
    logic        en;
    logic [31:0] dl;
    logic        eq;
    logic        due;
    logic [31:0] period32;
    run_t        r;

    assign tick     = (func_reg != FN_EDGE) && (func_reg != FN_LOAD);
    assign period32 = t_reg - last_edge_reg[lvl_reg];
    assign trial    = {rem_reg, quo_reg[25]};
    assign trial_ge = trial >= {1'b0, dvs_reg};

    // Pick the deadline under test
    always_comb
    begin
        en = 1'b0;
        dl = 32'd0;
        eq = tick;
        case (cmd.kind)
            TK_LOAD:
            begin
                en = raw_reg != stable_reg;
                dl = cand_time_reg + 32'(debounce_reg);
                eq = 1'b1;
            end
            TK_ZERO:
            begin
                en = ((run_reg.phase == PH_SPIN) || (run_reg.phase == PH_LAUNCH))
                    && !run_reg.quiet;
                dl = last_act_reg + 32'(zero_to_reg);
            end
            TK_IDLE:
            begin
                en = run_reg.phase == PH_SPIN;
                dl = last_act_reg + 32'(idle_reg);
            end
            TK_NORPM:
            begin
                en = (run_reg.phase == PH_LAUNCH) && !run_reg.have;
                dl = launch_time_reg + 32'(no_rpm_reg);
            end
            default:
            begin
                en = 1'b0;
            end
        endcase
        due = en && (before_f(dl, t_reg) || (eq && (dl == t_reg)));
    end

    // Next state of the block
    always_comb
    begin
        r                 = run_reg;
        raw_next          = raw_reg;
        stable_next       = stable_reg;
        cand_time_next    = cand_time_reg;
        cand_spin_next    = cand_spin_reg;
        last_edge_next[0] = last_edge_reg[0];
        last_edge_next[1] = last_edge_reg[1];
        last_act_next     = last_act_reg;
        launch_time_next  = launch_time_reg;
        pval_next         = pval_reg;
        pref_next         = pref_reg;
        period_next       = period_reg;
        sel_valid_next    = sel_valid_reg;
        sel_kind_next     = sel_kind_reg;
        sel_dl_next       = sel_dl_reg;

        if (cmd.start)
        begin
            r.fin        = 1'b0;
            r.lch        = 1'b0;
            r.pend       = 1'b0;
            r.pend_quiet = 1'b0;
            pval_next    = 1'b0;
            pref_next    = 1'b0;
            period_next  = 27'd0;
        end

        // Keep the earliest due deadline
        if (cmd.scan)
        begin
            if (cmd.scan_first)
            begin
                sel_valid_next = 1'b0;
            end
            if (due && (cmd.scan_first || !sel_valid_reg || before_f(dl, sel_dl_reg)))
            begin
                sel_valid_next = 1'b1;
                sel_kind_next  = cmd.kind;
                sel_dl_next    = dl;
            end
        end

        // Handle the selected timer
        if (cmd.apply && sel_valid_reg)
        begin
            case (sel_kind_reg)
                TK_LOAD:
                begin
                    stable_next = raw_reg;
                    if (raw_reg == LOAD_LVL)
                    begin
                        r = restart_f(r, 1'b1);
                    end
                    else if (r.phase == PH_SPIN)
                    begin
                        if (!cand_spin_reg)
                        begin
                            r = restart_f(r, 1'b0);
                        end
                        else
                        begin
                            launch_time_next = cand_time_reg;
                            r.phase      = PH_LAUNCH;
                            r.lch        = 1'b1;
                            r.pend       = 1'b1;
                            r.pend_quiet = 1'b1;
                        end
                    end
                    else if (r.phase == PH_READY)
                    begin
                        r = restart_f(r, 1'b0);
                    end
                end
                TK_ZERO:
                begin
                    r.now   = 16'd0;
                    r.based = 2'b00;
                    r.quiet = 1'b1;
                    if ((r.phase == PH_LAUNCH) && r.have)
                    begin
                        r = end_run_f(r);
                    end
                end
                TK_IDLE:
                begin
                    r = restart_f(r, 1'b1);
                end
                TK_NORPM:
                begin
                    r = end_run_f(r);
                end
                default:
                begin
                    r = run_reg;
                end
            endcase
        end

        // Finish test after a launch or a new speed
        if (cmd.check && r.pend)
        begin
            if (thr_hit(r, finish_pct_reg))
            begin
                r = end_run_f(r);
            end
            if (r.pend_quiet && r.quiet && r.have)
            begin
                r = end_run_f(r);
            end
            r.pend       = 1'b0;
            r.pend_quiet = 1'b0;
        end

        // Speed edge up to the point where a division is needed
        if (cmd.ev_edge && (r.phase != PH_WAIT))
        begin
            if (r.phase == PH_READY)
            begin
                r.phase = PH_SPIN;
            end
            if (r.ref_pol == REF_NONE)
            begin
                r.ref_pol = {1'b0, lvl_reg};
            end
            period_next = period32[26:0];
            if (!r.based[lvl_reg])
            begin
                last_edge_next[lvl_reg] = t_reg;
                last_act_next           = t_reg;
                r.based[lvl_reg]        = 1'b1;
                r.quiet                 = 1'b0;
            end
            else if ((period32 == 32'd0) || (period32 < {12'd0, min_period_reg}))
            begin
                period_next = period_reg;
            end
            else if (period32 > {5'd0, max_period_reg})
            begin
                last_edge_next[lvl_reg] = t_reg;
                last_act_next           = t_reg;
                r.now                   = 16'd0;
                r.quiet                 = 1'b0;
            end
        end

        // Take the converted speed if it is plausible
        if (cmd.rpm && (quo_reg <= {10'd0, rpm_limit_reg}))
        begin
            last_edge_next[lvl_reg] = t_reg;
            last_act_next           = t_reg;
            r.quiet      = 1'b0;
            r.now        = quo_reg[15:0];
            r.have       = 1'b1;
            pval_next    = 1'b1;
            pref_next    = {1'b0, lvl_reg} == r.ref_pol;
            if (r.now > r.peak)
            begin
                r.peak = r.now;
            end
            r.pend       = 1'b1;
            r.pend_quiet = 1'b0;
        end

        // Load sensor change restarts the debounce candidate
        if (cmd.ev_load)
        begin
            raw_next       = lvl_reg;
            cand_time_next = t_reg;
            cand_spin_next = r.phase == PH_SPIN;
        end

        run_next = r;
    end

    // Control and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg   <= 20'd100;
            max_period_reg   <= 27'd1000000;
            rpm_limit_reg    <= 16'd65535;
            finish_pct_reg   <= 7'd20;
            debounce_reg     <= 27'd20000;
            zero_to_reg      <= 30'd300000;
            idle_reg         <= 30'd5000000;
            no_rpm_reg       <= 30'd2000000;
            raw_reg          <= 1'b0;
            stable_reg       <= 1'b0;
            cand_time_reg    <= 32'd0;
            cand_spin_reg    <= 1'b0;
            last_edge_reg[0] <= 32'd0;
            last_edge_reg[1] <= 32'd0;
            last_act_reg     <= 32'd0;
            launch_time_reg  <= 32'd0;
            run_reg          <= '{phase: PH_WAIT, based: 2'b00, ref_pol: REF_NONE,
                                  quiet: 1'b1, have: 1'b0, now: 16'd0, peak: 16'd0,
                                  fin: 1'b0, lch: 1'b0, pend: 1'b0, pend_quiet: 1'b0};
            pval_reg         <= 1'b0;
            pref_reg         <= 1'b0;
            sel_valid_reg    <= 1'b0;
            sel_kind_reg     <= TK_LOAD;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_MIN_PERIOD: min_period_reg <= cfg_data[19:0];
                    CFG_MAX_PERIOD: max_period_reg <= cfg_data[26:0];
                    CFG_RPM_LIMIT:  rpm_limit_reg  <= cfg_data[15:0];
                    CFG_FINISH_PCT: finish_pct_reg <= cfg_data[6:0];
                    CFG_DEBOUNCE:   debounce_reg   <= cfg_data[26:0];
                    CFG_ZERO_TO:    zero_to_reg    <= cfg_data;
                    CFG_IDLE_RESET: idle_reg       <= cfg_data;
                    CFG_NO_RPM_TO:  no_rpm_reg     <= cfg_data;
                    default:        no_rpm_reg     <= no_rpm_reg;
                endcase
            end
            raw_reg          <= raw_next;
            stable_reg       <= stable_next;
            cand_time_reg    <= cand_time_next;
            cand_spin_reg    <= cand_spin_next;
            last_edge_reg[0] <= last_edge_next[0];
            last_edge_reg[1] <= last_edge_next[1];
            last_act_reg     <= last_act_next;
            launch_time_reg  <= launch_time_next;
            run_reg          <= run_next;
            pval_reg         <= pval_next;
            pref_reg         <= pref_next;
            sel_valid_reg    <= sel_valid_next;
            sel_kind_reg     <= sel_kind_next;
        end
    end

    // Item, divider and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg <= func;
            t_reg    <= time_us;
            lvl_reg  <= level;
        end
        period_reg <= period_next;
        sel_dl_reg <= sel_dl_next;
        if (cmd.div_init)
        begin
            dvs_reg <= DW'(period_reg) * DW'(PPT);
            rem_reg <= '0;
            quo_reg <= RPM_NUMERATOR;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? DW'(trial - {1'b0, dvs_reg}) : trial[DW-1:0];
            quo_reg <= {quo_reg[24:0], trial_ge};
        end
        if (cmd.latch)
        begin
            o_now_reg    <= run_reg.now;
            o_peak_reg   <= run_reg.peak;
            o_phase_reg  <= run_reg.phase;
            o_loaded_reg <= stable_reg == LOAD_LVL;
            o_fin_reg    <= run_reg.fin;
            o_lch_reg    <= run_reg.lch;
            o_pval_reg   <= pval_reg;
            o_period_reg <= pval_reg ? period_reg : 27'd0;
            o_ref_reg    <= pval_reg && pref_reg;
        end
    end

    assign sts.sel_valid = sel_valid_reg;
    assign sts.fin       = run_reg.fin;
    assign sts.need_div  = (run_reg.phase != PH_WAIT) && run_reg.based[lvl_reg]
                           && (period32 != 32'd0)
                           && (period32 >= {12'd0, min_period_reg})
                           && (period32 <= {5'd0, max_period_reg});
    assign sts.is_edge   = func_reg == FN_EDGE;
    assign sts.is_load   = func_reg == FN_LOAD;

    assign current_rpm       = o_now_reg;
    assign peak_rpm          = o_peak_reg;
    assign phase             = o_phase_reg;
    assign loaded            = o_loaded_reg;
    assign finished          = o_fin_reg;
    assign launched          = o_lch_reg;
    assign period_valid      = o_pval_reg;
    assign turn_period       = o_period_reg;
    assign is_reference_edge = o_ref_reg;

endmodule

/* design/srm_ctrl.sv */
module srm_ctrl #(
    parameter int unsigned TIMER_PASSES = srm_pkg::TIMER_PASSES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  srm_pkg::sts_t sts,
    output srm_pkg::cmd_t cmd
);
    import srm_pkg::*;

    localparam int unsigned PCW = $clog2(TIMER_PASSES + 1);
    localparam int unsigned DCW = $clog2(DIV_STEPS);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SCAN  = 10'b0000000010,
        S_APPLY = 10'b0000000100,
        S_CHECK = 10'b0000001000,
        S_EVENT = 10'b0000010000,
        S_DIVI  = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_RPM   = 10'b0010000000,
        S_RCHK  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t         state_reg, state_next;
    tkind_t         kind_reg, kind_next;
    logic [PCW-1:0] pass_reg, pass_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic           out_valid_reg, out_valid_next;

    // Sequence one item through timer passes, event and divider
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        kind_next      = kind_reg;
        pass_next      = pass_reg;
        div_cnt_next   = div_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    kind_next  = TK_LOAD;
                    pass_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if ((kind_reg == TK_LOAD) && sts.fin)
                begin
                    state_next = S_EVENT;
                end
                else
                begin
                    cmd.scan       = 1'b1;
                    cmd.kind       = kind_reg;
                    cmd.scan_first = kind_reg == TK_LOAD;
                    if (kind_reg == TK_NORPM)
                    begin
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        kind_next = tkind_t'(kind_reg + 2'd1);
                    end
                end
            end
            S_APPLY:
            begin
                if (sts.sel_valid)
                begin
                    cmd.apply  = 1'b1;
                    pass_next  = pass_reg + PCW'(1);
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_EVENT;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                kind_next = TK_LOAD;
                if (pass_reg == PCW'(TIMER_PASSES))
                begin
                    state_next = S_EVENT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_EVENT:
            begin
                state_next = S_DONE;
                if (!sts.fin)
                begin
                    if (sts.is_edge)
                    begin
                        cmd.ev_edge = 1'b1;
                        if (sts.need_div)
                        begin
                            state_next = S_DIVI;
                        end
                    end
                    else if (sts.is_load)
                    begin
                        cmd.ev_load = 1'b1;
                    end
                end
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(DIV_STEPS - 1))
                begin
                    state_next = S_RPM;
                end
            end
            S_RPM:
            begin
                cmd.rpm    = 1'b1;
                state_next = S_RCHK;
            end
            S_RCHK:
            begin
                cmd.check  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until it is transferred
    always_comb
    begin
        if (cmd.latch)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= TK_LOAD;
            pass_reg      <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            pass_reg      <= pass_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_SCAN)
        else $error("accepted item did not start a timer scan");

    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pass_reg <= PCW'(TIMER_PASSES))
        else $error("timer pass count beyond limit");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && div_cnt_reg == DCW'(DIV_STEPS - 1) |=> state_reg == S_RPM)
        else $error("divider did not finish after its last step");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && !out_stall |=> state_reg == S_IDLE && out_valid)
        else $error("finished item not handed to the output register");

endmodule
